// ===== hw/rtl/fmh_pkg.sv =====
// Shared types, codes and run-length code tables for the fax line normalizer.
`default_nettype none
package fmh_pkg;

  typedef enum logic [1:0] {CMD_BITS, CMD_EOL, CMD_FLUSH, CMD_END} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [12:0] code;
    logic [3:0]  len;
  } cmd_t;

  typedef struct packed {
    logic       align_eol;
    logic [3:0] line_padding;
    logic       black_separator;
    logic [1:0] top_blank_lines;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [11:0] run;
  } mh_hit_t;

  localparam logic [1:0] REG_ALIGN_EOL       = 2'd0;
  localparam logic [1:0] REG_LINE_PADDING    = 2'd1;
  localparam logic [1:0] REG_BLACK_SEPARATOR = 2'd2;
  localparam logic [1:0] REG_TOP_BLANK_LINES = 2'd3;

  localparam logic [2:0] OP_DATA      = 3'd0;
  localparam logic [2:0] OP_DOC_START = 3'd1;
  localparam logic [2:0] OP_DOC_SEP   = 3'd2;
  localparam logic [2:0] OP_DOC_LAST  = 3'd3;
  localparam logic [2:0] OP_FINISH    = 3'd4;

  localparam logic [12:0] EOL_CODE    = 13'h800;
  localparam logic [12:0] WHITE_A     = 13'h1b2;
  localparam logic [12:0] WHITE_B     = 13'h0ac;
  localparam logic [12:0] BLACK_B     = 13'h14c0;
  localparam logic [12:0] BLACK_C     = 13'h3b0;
  localparam logic [3:0]  PAD_LIMIT   = 4'd8;

  // Codes are written in transmission order, first bit as the MSB of len bits.
  localparam logic [12:0] WT_CODE [64] = '{
    13'b00110101, 13'b000111, 13'b0111, 13'b1000, 13'b1011, 13'b1100, 13'b1110, 13'b1111,
    13'b10011, 13'b10100, 13'b00111, 13'b01000, 13'b001000, 13'b000011, 13'b110100,
    13'b110101, 13'b101010, 13'b101011, 13'b0100111, 13'b0001100, 13'b0001000,
    13'b0010111, 13'b0000011, 13'b0000100, 13'b0101000, 13'b0101011, 13'b0010011,
    13'b0100100, 13'b0011000, 13'b00000010, 13'b00000011, 13'b00011010,
    13'b00011011, 13'b00010010, 13'b00010011, 13'b00010100, 13'b00010101, 13'b00010110,
    13'b00010111, 13'b00101000, 13'b00101001, 13'b00101010, 13'b00101011, 13'b00101100,
    13'b00101101, 13'b00000100, 13'b00000101, 13'b00001010, 13'b00001011, 13'b01010010,
    13'b01010011, 13'b01010100, 13'b01010101, 13'b00100100, 13'b00100101, 13'b01011000,
    13'b01011001, 13'b01011010, 13'b01011011, 13'b01001010, 13'b01001011, 13'b00110010,
    13'b00110011, 13'b00110100
  };
  localparam logic [3:0] WT_LEN [64] = '{
    4'd8, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
  };
  localparam logic [12:0] WM_CODE [27] = '{
    13'b11011, 13'b10010, 13'b010111, 13'b0110111, 13'b00110110, 13'b00110111,
    13'b01100100, 13'b01100101, 13'b01101000, 13'b01100111, 13'b011001100,
    13'b011001101, 13'b011010010, 13'b011010011, 13'b011010100, 13'b011010101,
    13'b011010110, 13'b011010111, 13'b011011000, 13'b011011001, 13'b011011010,
    13'b011011011, 13'b010011000, 13'b010011001, 13'b010011010, 13'b011000,
    13'b010011011
  };
  localparam logic [3:0] WM_LEN [27] = '{
    4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
    4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd6, 4'd9
  };
  localparam logic [12:0] BT_CODE [64] = '{
    13'b0000110111, 13'b010, 13'b11, 13'b10, 13'b011, 13'b0011, 13'b0010, 13'b00011,
    13'b000101, 13'b000100, 13'b0000100, 13'b0000101, 13'b0000111, 13'b00000100,
    13'b00000111, 13'b000011000, 13'b0000010111, 13'b0000011000, 13'b0000001000,
    13'b00001100111, 13'b00001101000, 13'b00001101100, 13'b00000110111,
    13'b00000101000, 13'b00000010111, 13'b00000011000, 13'b000011001010,
    13'b000011001011, 13'b000011001100, 13'b000011001101, 13'b000001101000,
    13'b000001101001, 13'b000001101010, 13'b000001101011, 13'b000011010010,
    13'b000011010011, 13'b000011010100, 13'b000011010101, 13'b000011010110,
    13'b000011010111, 13'b000001101100, 13'b000001101101, 13'b000011011010,
    13'b000011011011, 13'b000001010100, 13'b000001010101, 13'b000001010110,
    13'b000001010111, 13'b000001100100, 13'b000001100101, 13'b000001010010,
    13'b000001010011, 13'b000000100100, 13'b000000110111, 13'b000000111000,
    13'b000000100111, 13'b000000101000, 13'b000001011000, 13'b000001011001,
    13'b000000101011, 13'b000000101100, 13'b000001011010, 13'b000001100110,
    13'b000001100111
  };
  localparam logic [3:0] BT_LEN [64] = '{
    4'd10, 4'd3, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5,
    4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9,
    4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12
  };
  localparam logic [12:0] BM_CODE [27] = '{
    13'b0000001111, 13'b000011001000, 13'b000011001001, 13'b000001011011,
    13'b000000110011, 13'b000000110100, 13'b000000110101, 13'b0000001101100,
    13'b0000001101101, 13'b0000001001010, 13'b0000001001011, 13'b0000001001100,
    13'b0000001001101, 13'b0000001110010, 13'b0000001110011, 13'b0000001110100,
    13'b0000001110101, 13'b0000001110110, 13'b0000001110111, 13'b0000001010010,
    13'b0000001010011, 13'b0000001010100, 13'b0000001010101, 13'b0000001011010,
    13'b0000001011011, 13'b0000001100100, 13'b0000001100101
  };
  localparam logic [3:0] BM_LEN [27] = '{
    4'd10, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd13, 4'd13, 4'd13,
    4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13,
    4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13
  };
  localparam logic [12:0] EX_CODE [13] = '{
    13'b00000001000, 13'b00000001100, 13'b00000001101, 13'b000000010010,
    13'b000000010011, 13'b000000010100, 13'b000000010101, 13'b000000010110,
    13'b000000010111, 13'b000000011100, 13'b000000011101, 13'b000000011110,
    13'b000000011111
  };
  localparam logic [3:0] EX_LEN [13] = '{
    4'd11, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd12, 4'd12, 4'd12
  };

  function automatic cmd_t mk_cmd(input cmd_kind_t kind, input logic [12:0] code,
                                  input logic [3:0] len);
    cmd_t c;
    c.kind = kind;
    c.code = code;
    c.len  = len;
    return c;
  endfunction

  // w[k] is the k-th received bit; v holds the code with its first bit as MSB.
  function automatic logic code_match(input logic [12:0] w, input logic [12:0] v,
                                      input logic [3:0] l);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 13; k++) begin
      if (4'(k) < l) begin
        if (w[k] != v[l - 4'(k) - 4'd1]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Terminating codes win over make-up codes, which win over extended make-up.
  function automatic mh_hit_t mh_lookup(input logic [12:0] w, input logic color);
    mh_hit_t h;
    logic found;
    h.len = 4'd0;
    h.run = 12'd0;
    found = 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (!found && code_match(w, color ? BT_CODE[i] : WT_CODE[i],
                               color ? BT_LEN[i] : WT_LEN[i])) begin
        found = 1'b1;
        h.len = color ? BT_LEN[i] : WT_LEN[i];
        h.run = 12'(i);
      end
    end
    for (int i = 0; i < 27; i++) begin
      if (!found && code_match(w, color ? BM_CODE[i] : WM_CODE[i],
                               color ? BM_LEN[i] : WM_LEN[i])) begin
        found = 1'b1;
        h.len = color ? BM_LEN[i] : WM_LEN[i];
        h.run = 12'(64 * (i + 1));
      end
    end
    for (int i = 0; i < 13; i++) begin
      if (!found && code_match(w, EX_CODE[i], EX_LEN[i])) begin
        found = 1'b1;
        h.len = EX_LEN[i];
        h.run = 12'(1792 + 64 * i);
      end
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fmh_cmd_fifo.sv =====
// Small command queue between the decoder front and the bit writer.
`default_nettype none
module fmh_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire fmh_pkg::cmd_t wr_cmd,
  output logic              full,
  input  wire logic         pop,
  output fmh_pkg::cmd_t     rd_cmd,
  output logic              empty
);
  import fmh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_cmd;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fmh_front.sv =====
// Decoder front: takes input items, decodes run codes and queues writer commands.
`default_nettype none
module fmh_front #(
  parameter int LOOKAHEAD   = 20,
  parameter int COLUMN_BITS = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fmh_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_op,
  input  wire logic [7:0]    in_byte,
  output logic               push,
  output fmh_pkg::cmd_t      cmd,
  input  wire logic          full
);
  import fmh_pkg::*;

  localparam int IN_W  = LOOKAHEAD + 8;
  localparam int CNT_W = $clog2(IN_W + 1);
  localparam int SUM_W = ((COLUMN_BITS > 12) ? COLUMN_BITS : 12) + 1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SKIP   = 2'd1;
  localparam logic [1:0] MODE_FILL   = 2'd2;
  localparam logic [1:0] MODE_DONE   = 2'd3;

  typedef enum logic [3:0] {
    F_IDLE, F_DEC, F_PRE, F_HEOL, F_WL, F_BLK, F_RTC, F_FLUSH, F_END
  } state_t;

  state_t                 state;
  logic [IN_W-1:0]        in_bits;
  logic [CNT_W-1:0]       in_count;
  logic [1:0]             mode;
  logic                   color;
  logic [COLUMN_BITS-1:0] column;
  logic [2:0]             streak;
  logic                   first_doc;
  logic [1:0]             part;
  logic [1:0]             wl_left;
  logic                   blk_pend;
  logic [2:0]             rtc_left;

  mh_hit_t                hit;
  logic [12:0]            mask;
  logic [SUM_W-1:0]       sum;
  logic                   can_step;
  logic                   go;
  logic [2:0]             streak_inc;
  logic [1:0]             wl_dec;

  always_comb begin
    hit        = mh_lookup(in_bits[12:0], color);
    mask       = 13'((14'd1 << hit.len) - 14'd1);
    sum        = SUM_W'(column) + SUM_W'(hit.run);
    can_step   = (in_count >= CNT_W'(LOOKAHEAD)) && (mode != MODE_DONE);
    streak_inc = streak + 3'd1;
    wl_dec     = wl_left - 2'd1;
    push       = 1'b0;
    cmd        = mk_cmd(CMD_END, 13'd0, 4'd0);
    unique case (state)
      F_DEC: begin
        if (can_step) begin
          if (mode == MODE_NORMAL && in_bits[7:0] != 8'd0 && hit.len != 4'd0) begin
            push = 1'b1;
            cmd  = mk_cmd(CMD_BITS, in_bits[12:0] & mask, hit.len);
          end else if (mode == MODE_FILL && in_bits[0] && column != '0) begin
            push = 1'b1;
            cmd  = mk_cmd(CMD_EOL, 13'd0, 4'd0);
          end
        end
      end
      F_PRE: begin
        if (cfg.align_eol || cfg.line_padding != 4'd0) begin
          push = 1'b1;
          cmd  = mk_cmd(CMD_BITS, 13'd0, 4'd4);
        end
      end
      F_HEOL: begin
        push = 1'b1;
        cmd  = mk_cmd(CMD_BITS, EOL_CODE, 4'd12);
      end
      F_WL: begin
        push = 1'b1;
        unique case (part)
          2'd0:    cmd = mk_cmd(CMD_BITS, WHITE_A, 4'd9);
          2'd1:    cmd = mk_cmd(CMD_BITS, WHITE_B, 4'd8);
          default: cmd = mk_cmd(CMD_EOL, 13'd0, 4'd0);
        endcase
      end
      F_BLK: begin
        push = 1'b1;
        unique case (part)
          2'd0:    cmd = mk_cmd(CMD_BITS, WHITE_B, 4'd8);
          2'd1:    cmd = mk_cmd(CMD_BITS, BLACK_B, 4'd13);
          2'd2:    cmd = mk_cmd(CMD_BITS, BLACK_C, 4'd10);
          default: cmd = mk_cmd(CMD_EOL, 13'd0, 4'd0);
        endcase
      end
      F_RTC: begin
        push = 1'b1;
        cmd  = mk_cmd(CMD_EOL, 13'd0, 4'd0);
      end
      F_FLUSH: begin
        push = 1'b1;
        cmd  = mk_cmd(CMD_FLUSH, 13'd0, 4'd0);
      end
      F_END: begin
        push = 1'b1;
        cmd  = mk_cmd(CMD_END, 13'd0, 4'd0);
      end
      default: push = 1'b0;
    endcase
    go       = !push || !full;
    in_ready = (state == F_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      in_bits   <= '0;
      in_count  <= '0;
      mode      <= MODE_NORMAL;
      color     <= 1'b0;
      column    <= '0;
      streak    <= '0;
      first_doc <= 1'b1;
      part      <= '0;
      wl_left   <= '0;
      blk_pend  <= 1'b0;
      rtc_left  <= '0;
    end else if (go) begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            part <= '0;
            if (in_op != OP_DATA && in_op <= OP_FINISH) begin
              in_bits  <= '0;
              in_count <= '0;
              mode     <= MODE_NORMAL;
              color    <= 1'b0;
              column   <= '0;
              streak   <= '0;
            end
            priority case (in_op)
              OP_DATA: begin
                if (mode != MODE_DONE) begin
                  in_bits  <= in_bits | (IN_W'(in_byte) << in_count);
                  in_count <= in_count + CNT_W'(8);
                  state    <= F_DEC;
                end else begin
                  state <= F_END;
                end
              end
              OP_DOC_START: begin
                first_doc <= 1'b0;
                state     <= first_doc ? F_PRE : F_END;
              end
              OP_DOC_SEP: begin
                wl_left  <= 2'd2;
                blk_pend <= cfg.black_separator;
                state    <= F_WL;
              end
              OP_FINISH: begin
                first_doc <= 1'b1;
                rtc_left  <= 3'd6;
                state     <= F_RTC;
              end
              default: state <= F_END;
            endcase
          end
        end
        F_DEC: begin
          if (!can_step) begin
            state <= F_END;
          end else if (mode == MODE_NORMAL) begin
            if (in_bits[7:0] == 8'd0) begin
              in_bits  <= in_bits >> 8;
              in_count <= in_count - CNT_W'(8);
              mode     <= MODE_FILL;
            end else if (hit.len == 4'd0) begin
              mode <= MODE_SKIP;
            end else begin
              in_bits  <= in_bits >> hit.len;
              in_count <= in_count - CNT_W'(hit.len);
              column   <= (sum > SUM_W'(COL_MAX)) ? COL_MAX : sum[COLUMN_BITS-1:0];
              if (hit.run < 12'd64) color <= ~color;
            end
          end else if (mode == MODE_SKIP) begin
            if (in_bits[5:0] == 6'd0) begin
              mode <= MODE_FILL;
            end else begin
              in_bits  <= in_bits >> 1;
              in_count <= in_count - CNT_W'(1);
            end
          end else begin
            in_bits  <= in_bits >> 1;
            in_count <= in_count - CNT_W'(1);
            if (in_bits[0]) begin
              color <= 1'b0;
              if (column == '0) begin
                streak <= streak_inc;
                mode   <= (streak_inc >= 3'd4) ? MODE_DONE : MODE_NORMAL;
              end else begin
                column <= '0;
                streak <= '0;
                mode   <= MODE_NORMAL;
              end
            end
          end
        end
        F_PRE: state <= F_HEOL;
        F_HEOL: begin
          if (cfg.top_blank_lines != 2'd0) begin
            wl_left  <= cfg.top_blank_lines;
            blk_pend <= 1'b0;
            part     <= '0;
            state    <= F_WL;
          end else begin
            state <= F_END;
          end
        end
        F_WL: begin
          if (part == 2'd2) begin
            part    <= '0;
            wl_left <= wl_dec;
            if (wl_dec != 2'd0 && blk_pend) begin
              blk_pend <= 1'b0;
              state    <= F_BLK;
            end else if (wl_dec != 2'd0) begin
              state <= F_WL;
            end else begin
              state <= F_END;
            end
          end else begin
            part <= part + 2'd1;
          end
        end
        F_BLK: begin
          if (part == 2'd3) begin
            part  <= '0;
            state <= F_WL;
          end else begin
            part <= part + 2'd1;
          end
        end
        F_RTC: begin
          rtc_left <= rtc_left - 3'd1;
          if (rtc_left == 3'd1) state <= F_FLUSH;
        end
        F_FLUSH: state <= F_END;
        F_END:   state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fmh_writer.sv =====
// Bit writer back end: packs code bits into bytes, pads lines and drives the output.
`default_nettype none
module fmh_writer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fmh_pkg::cfg_t cfg,
  input  wire fmh_pkg::cmd_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tlast
);
  import fmh_pkg::*;

  typedef enum logic [2:0] {
    W_IDLE, W_DRAIN, W_E1, W_E2, W_E3, W_E4, W_FL, W_ENDS
  } state_t;

  state_t      state;
  state_t      ret;
  logic [23:0] out_bits;
  logic [4:0]  out_count;
  logic [4:0]  line_bytes;
  logic        pend_valid;
  logic [7:0]  pend_byte;

  logic        out_free;
  logic        can_emit;
  logic        emit_req;
  logic        emit_fire;
  logic [3:0]  pad_eff;

  always_comb begin
    out_free  = !m_tvalid || m_tready;
    can_emit  = !pend_valid || out_free;
    emit_req  = (state == W_DRAIN && out_count >= 5'd8) ||
                (state == W_FL && out_count != 5'd0);
    emit_fire = emit_req && can_emit;
    pad_eff   = (cfg.line_padding > PAD_LIMIT) ? PAD_LIMIT : cfg.line_padding;
    pop       = (state == W_IDLE) && !empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= W_IDLE;
      ret        <= W_IDLE;
      out_bits   <= '0;
      out_count  <= '0;
      line_bytes <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // Output side: one byte is held back so the item's final byte can be marked.
      if (emit_fire) begin
        if (pend_valid) begin
          m_tvalid <= 1'b1;
          m_tdata  <= pend_byte;
          m_tlast  <= 1'b0;
        end else if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        pend_byte  <= out_bits[7:0];
        pend_valid <= 1'b1;
        // The flush clears the line count itself.
        if (line_bytes < 5'd31 && state != W_FL) line_bytes <= line_bytes + 5'd1;
      end else if (state == W_ENDS && pend_valid && out_free) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= pend_byte;
        m_tlast    <= 1'b1;
        pend_valid <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        W_IDLE: begin
          if (!empty) begin
            unique case (head.kind)
              CMD_BITS: begin
                out_bits  <= out_bits | (24'(head.code) << out_count);
                out_count <= out_count + 5'(head.len);
                ret       <= W_IDLE;
                state     <= W_DRAIN;
              end
              CMD_EOL:   state <= W_E1;
              CMD_FLUSH: state <= W_FL;
              default:   state <= W_ENDS;
            endcase
          end
        end
        W_DRAIN: begin
          if (out_count >= 5'd8) begin
            if (can_emit) begin
              out_bits  <= out_bits >> 8;
              out_count <= out_count - 5'd8;
            end
          end else begin
            state <= ret;
          end
        end
        W_E1: begin
          if (pad_eff != 4'd0) begin
            if (out_count <= 5'd4) begin
              out_count <= 5'd4;
              state     <= W_E2;
            end else begin
              out_count <= 5'd12;
              ret       <= W_E2;
              state     <= W_DRAIN;
            end
          end else begin
            state <= W_E3;
          end
        end
        W_E2: begin
          if (line_bytes < 5'(pad_eff)) begin
            out_count <= out_count + 5'd8;
            ret       <= W_E2;
            state     <= W_DRAIN;
          end else begin
            line_bytes <= '0;
            state      <= W_E3;
          end
        end
        W_E3: begin
          if (cfg.align_eol && out_count > 5'd4) begin
            out_count <= 5'd12;
            ret       <= W_E4;
            state     <= W_DRAIN;
          end else begin
            if (cfg.align_eol) out_count <= 5'd4;
            state <= W_E4;
          end
        end
        W_E4: begin
          out_bits  <= out_bits | (24'(EOL_CODE) << out_count);
          out_count <= out_count + 5'd12;
          ret       <= W_IDLE;
          state     <= W_DRAIN;
        end
        W_FL: begin
          if (out_count == 5'd0 || can_emit) begin
            out_bits   <= '0;
            out_count  <= '0;
            line_bytes <= '0;
            state      <= W_IDLE;
          end
        end
        default: begin
          if (!pend_valid || out_free) state <= W_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fax_mh_line_normalizer.sv =====
// Top level of the G3 fax Modified Huffman line normalizer.
`default_nettype none
// The block reads G3 fax data one byte per transfer (first bit in the LSB),
// decodes the one-dimensional white and black run codes, and writes a cleaned
// stream: every valid code is passed on with its original bits, EOLs after
// empty lines are dropped, invalid codes are skipped up to six zero bits, and
// four EOLs in a row end the document. Control transfers (document start, end
// with separator, last document end, finish) add the opening EOL, blank top
// lines, separator lines and the closing RTC. Each input transfer yields zero
// or more output bytes, the final one marked with tlast. The input accepts one
// transfer at a time. The decoder takes one code, skipped bit, fill bit or
// dropped zero byte per step, and a control transfer queues its writer
// commands in order. The bit writer packs code commands into output bytes and
// adds EOLs with their padding and alignment. The decoder front and the bit
// writer are separated by a command queue of QUEUE_DEPTH entries, so decoding
// overlaps with byte output and output stalls only back up the writer until
// the queue fills. Configuration is written through cfg_we/cfg_index/cfg_data
// and should change only while the block is idle.
module fax_mh_line_normalizer #(
  parameter int LOOKAHEAD   = 20,
  parameter int COLUMN_BITS = 12,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic [2:0] s_tuser,   // [2:0] op
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data
);
  import fmh_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t wr_cmd;
  logic full;
  logic pop;
  cmd_t rd_cmd;
  logic empty;

  // Configuration registers, written one at a time by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALIGN_EOL:       cfg.align_eol       <= cfg_data[0];
        REG_LINE_PADDING:    cfg.line_padding    <= cfg_data;
        REG_BLACK_SEPARATOR: cfg.black_separator <= cfg_data[0];
        default:             cfg.top_blank_lines <= cfg_data[1:0];
      endcase
    end
  end

  // The front decodes input and turns each transfer into writer commands.
  fmh_front #(
    .LOOKAHEAD  (LOOKAHEAD),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_op   (s_tuser),
    .in_byte (s_tdata),
    .push    (push),
    .cmd     (wr_cmd),
    .full    (full)
  );

  fmh_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_cmd(wr_cmd),
    .full  (full),
    .pop   (pop),
    .rd_cmd(rd_cmd),
    .empty (empty)
  );

  // The writer packs bits, inserts padding and alignment and drives the output.
  fmh_writer u_writer (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (rd_cmd),
    .empty   (empty),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // The writer never takes a command from an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("writer popped an empty command queue");

  // Each accepted transfer takes the front out of idle for the next cycle.
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("front accepted two transfers back to back");

  // Reset leaves the command queue empty.
  assert property (@(posedge clk) rst |=> empty)
    else $error("command queue not empty after reset");

endmodule
`default_nettype wire

// ===== sim/fax_mh_line_normalizer_tb.sv =====
// Self-checking testbench for the G3 fax Modified Huffman line normalizer.
`default_nettype none
// Random and directed fax streams are sent in documents with control transfers
// between them. A behavioral model of the decoder and bit writer predicts the
// output bytes of every accepted transfer, and the monitor checks each output
// transfer against the oldest prediction. Configuration changes only while the
// block is drained.
module fax_mh_line_normalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmh_pkg::*;

  typedef struct {
    logic [2:0] op;
    logic [7:0] data;
  } fax_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
  } fax_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  fax_mh_line_normalizer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int LOOKAHEAD_BITS = 20;
  localparam int COLUMN_MAX     = 4095;
  localparam int STALL_LIMIT    = 20000;

  // Run-length code tables in transmission order, first bit leftmost.
  string wterm[64] = '{
    "00110101","000111","0111","1000","1011","1100","1110","1111",
    "10011","10100","00111","01000","001000","000011","110100","110101",
    "101010","101011","0100111","0001100","0001000","0010111","0000011","0000100",
    "0101000","0101011","0010011","0100100","0011000","00000010","00000011","00011010",
    "00011011","00010010","00010011","00010100","00010101","00010110","00010111","00101000",
    "00101001","00101010","00101011","00101100","00101101","00000100","00000101","00001010",
    "00001011","01010010","01010011","01010100","01010101","00100100","00100101","01011000",
    "01011001","01011010","01011011","01001010","01001011","00110010","00110011","00110100"};
  string wmake[27] = '{
    "11011","10010","010111","0110111","00110110","00110111","01100100","01100101",
    "01101000","01100111","011001100","011001101","011010010","011010011","011010100",
    "011010101","011010110","011010111","011011000","011011001","011011010","011011011",
    "010011000","010011001","010011010","011000","010011011"};
  string bterm[64] = '{
    "0000110111","010","11","10","011","0011","0010","00011",
    "000101","000100","0000100","0000101","0000111","00000100","00000111","000011000",
    "0000010111","0000011000","0000001000","00001100111","00001101000","00001101100",
    "00000110111","00000101000","00000010111","00000011000","000011001010",
    "000011001011","000011001100","000011001101","000001101000","000001101001",
    "000001101010","000001101011","000011010010","000011010011","000011010100",
    "000011010101","000011010110","000011010111","000001101100","000001101101",
    "000011011010","000011011011","000001010100","000001010101","000001010110",
    "000001010111","000001100100","000001100101","000001010010","000001010011",
    "000000100100","000000110111","000000111000","000000100111","000000101000",
    "000001011000","000001011001","000000101011","000000101100","000001011010",
    "000001100110","000001100111"};
  string bmake[27] = '{
    "0000001111","000011001000","000011001001","000001011011","000000110011",
    "000000110100","000000110101","0000001101100","0000001101101","0000001001010",
    "0000001001011","0000001001100","0000001001101","0000001110010","0000001110011",
    "0000001110100","0000001110101","0000001110110","0000001110111","0000001010010",
    "0000001010011","0000001010100","0000001010101","0000001011010","0000001011011",
    "0000001100100","0000001100101"};
  string xmake[13] = '{
    "00000001000","00000001100","00000001101","000000010010","000000010011",
    "000000010100","000000010101","000000010110","000000010111","000000011100",
    "000000011101","000000011110","000000011111"};

  // Model state: registers, decoder and bit writer.
  int unsigned  cfg_align, cfg_pad, cfg_sep, cfg_top;
  logic [63:0]  dec_bits;
  int unsigned  dec_count, dec_mode, dec_color, dec_column, dec_eols;
  int unsigned  wr_bits, wr_count, wr_line_bytes, wr_first_doc;

  fax_item_t   pending_items[$];
  fax_byte_t   expected_bytes[$];
  int          errors = 0;
  int          bytes_seen = 0;

  function automatic void write_byte(int unsigned b);
    fax_byte_t e;
    e.out_byte = b[7:0];
    e.last = 1'b0;
    expected_bytes.push_back(e);
    if (wr_line_bytes < 31) wr_line_bytes++;
  endfunction

  function automatic void write_bits(int unsigned code, int unsigned len);
    wr_bits |= (code & ((32'd1 << len) - 1)) << wr_count;
    wr_count += len;
    while (wr_count >= 8) begin
      write_byte(wr_bits & 8'hff);
      wr_bits >>= 8;
      wr_count -= 8;
    end
    wr_bits &= 32'hffffff;
  endfunction

  // The EOL mark may be preceded by alignment and by zero fill up to the
  // minimum line length; both end with four spare bits so the EOL closes a byte.
  function automatic void write_eol();
    int unsigned pad;
    pad = cfg_pad > 8 ? 8 : cfg_pad;
    if (pad > 0) begin
      while (wr_count != 4) write_bits(0, 1);
      while (wr_line_bytes < pad) write_bits(0, 8);
      wr_line_bytes = 0;
    end
    if (cfg_align != 0) while (wr_count != 4) write_bits(0, 1);
    write_bits(EOL_CODE, 12);
  endfunction

  function automatic void write_white_line();
    write_bits(WHITE_A, 9);
    write_bits(WHITE_B, 8);
    write_eol();
  endfunction

  function automatic int unsigned code_len(string s);
    for (int n = 0; n < s.len(); n++) begin
      if (n >= dec_count) return 0;
      if (dec_bits[n] != (s[n] == "1")) return 0;
    end
    return s.len();
  endfunction

  // Terminating codes are tried first, then make-up, then extended make-up.
  function automatic int unsigned lookup_code(output int unsigned run);
    int unsigned n;
    run = 0;
    for (int i = 0; i < 64; i++) begin
      n = code_len(dec_color != 0 ? bterm[i] : wterm[i]);
      if (n != 0) begin
        run = i;
        return n;
      end
    end
    for (int i = 0; i < 27; i++) begin
      n = code_len(dec_color != 0 ? bmake[i] : wmake[i]);
      if (n != 0) begin
        run = 64 * (i + 1);
        return n;
      end
    end
    for (int i = 0; i < 13; i++) begin
      n = code_len(xmake[i]);
      if (n != 0) begin
        run = 1792 + 64 * i;
        return n;
      end
    end
    return 0;
  endfunction

  function automatic void drop_bits(int unsigned n);
    dec_bits >>= n;
    dec_count -= n;
  endfunction

  // Empty lines only count toward the end of the document; others are closed.
  function automatic void line_end();
    dec_color = 0;
    dec_mode = 0;
    if (dec_column == 0) begin
      dec_eols++;
      if (dec_eols >= 4) dec_mode = 3;
    end else begin
      dec_column = 0;
      dec_eols = 0;
      write_eol();
    end
  endfunction

  function automatic void decode_runs();
    int unsigned run, len;
    while (dec_count >= LOOKAHEAD_BITS && dec_mode != 3) begin
      if (dec_mode == 0) begin
        if (dec_bits[7:0] == 8'h00) begin
          drop_bits(8);
          dec_mode = 2;
        end else begin
          len = lookup_code(run);
          if (len == 0) dec_mode = 1;
          else begin
            write_bits(dec_bits[31:0] & ((32'd1 << len) - 1), len);
            drop_bits(len);
            dec_column = (dec_column + run > COLUMN_MAX) ? COLUMN_MAX : dec_column + run;
            if (run < 64) dec_color ^= 1;
          end
        end
      end else if (dec_mode == 1) begin
        // Resynchronize: shift until six zero bits lead.
        if (dec_bits[5:0] == 6'd0) dec_mode = 2;
        else drop_bits(1);
      end else begin
        len = dec_bits[0];
        drop_bits(1);
        if (len != 0) line_end();
      end
    end
  endfunction

  function automatic void clear_decoder();
    dec_bits = '0;
    dec_count = 0;
    dec_mode = 0;
    dec_color = 0;
    dec_column = 0;
    dec_eols = 0;
  endfunction

  function automatic void reset_model();
    cfg_align = 0;
    cfg_pad = 0;
    cfg_sep = 0;
    cfg_top = 0;
    clear_decoder();
    wr_bits = 0;
    wr_count = 0;
    wr_line_bytes = 0;
    wr_first_doc = 1;
  endfunction

  function automatic void predict_transfer(fax_item_t it);
    int first;
    first = expected_bytes.size();
    case (it.op)
      OP_DATA: begin
        if (dec_mode != 3) begin
          dec_bits |= 64'(it.data) << dec_count;
          dec_count += 8;
          decode_runs();
        end
      end
      OP_DOC_START: begin
        if (wr_first_doc != 0) begin
          if (cfg_align != 0 || cfg_pad > 0) write_bits(0, 4);
          write_bits(EOL_CODE, 12);
          wr_first_doc = 0;
          for (int i = 0; i < cfg_top; i++) write_white_line();
        end
        clear_decoder();
      end
      OP_DOC_SEP: begin
        clear_decoder();
        write_white_line();
        if (cfg_sep != 0) begin
          write_bits(WHITE_B, 8);
          write_bits(BLACK_B, 13);
          write_bits(BLACK_C, 10);
          write_eol();
        end
        write_white_line();
      end
      OP_DOC_LAST: clear_decoder();
      OP_FINISH: begin
        // Six EOLs form the RTC, then the partial byte is flushed.
        for (int i = 0; i < 6; i++) write_eol();
        if (wr_count != 0) write_byte(wr_bits & 8'hff);
        clear_decoder();
        wr_bits = 0;
        wr_count = 0;
        wr_line_bytes = 0;
        wr_first_doc = 1;
      end
      default: ;
    endcase
    if (expected_bytes.size() > first) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers: G3 bits are collected in transmission order and
  // packed into data transfers, first bit in the LSB.
  // ---------------------------------------------------------------------
  bit line_bits[$];

  task automatic queue_item(logic [2:0] op, logic [7:0] data);
    fax_item_t it;
    it.op = op;
    it.data = data;
    pending_items.push_back(it);
  endtask

  task automatic add_code(string s);
    for (int i = 0; i < s.len(); i++) line_bits.push_back(s[i] == "1");
  endtask

  task automatic add_zeros(int n);
    for (int i = 0; i < n; i++) line_bits.push_back(1'b0);
  endtask

  task automatic add_eol();
    add_zeros(11);
    line_bits.push_back(1'b1);
  endtask

  task automatic pack_bits(bit flush);
    logic [7:0] b;
    if (flush) while (line_bits.size() % 8 != 0) line_bits.push_back(1'b0);
    while (line_bits.size() >= 8) begin
      for (int i = 0; i < 8; i++) b[i] = line_bits.pop_front();
      queue_item(OP_DATA, b);
    end
  endtask

  // One scan line of alternating runs with optional make-up codes, fill,
  // corrupted bits and extra empty lines.
  task automatic add_line();
    int color, runs;
    color = 0;
    runs = $urandom_range(1, 6);
    for (int r = 0; r < runs; r++) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 3) == 0) add_code(xmake[$urandom_range(0, 12)]);
        else if (color != 0) add_code(bmake[$urandom_range(0, 26)]);
        else add_code(wmake[$urandom_range(0, 26)]);
      end
      if (color != 0) add_code(bterm[$urandom_range(0, $urandom_range(0, 3) == 0 ? 63 : 15)]);
      else add_code(wterm[$urandom_range(0, $urandom_range(0, 3) == 0 ? 63 : 15)]);
      color ^= 1;
    end
    if ($urandom_range(0, 9) == 0)
      for (int i = 0; i < 8; i++) line_bits.push_back($urandom_range(0, 1));
    add_zeros($urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : 0);
    add_eol();
    if ($urandom_range(0, 5) == 0) add_eol();
    pack_bits(1'b0);
  endtask

  task automatic add_document(int lines, bit last_doc);
    queue_item(OP_DOC_START, '0);
    for (int l = 0; l < lines; l++) add_line();
    // Four EOLs end the page; zero bytes after it give the decoder lookahead.
    if ($urandom_range(0, 3) != 0) for (int i = 0; i < 4; i++) add_eol();
    add_zeros(24);
    pack_bits(1'b1);
    if ($urandom_range(0, 4) == 0) queue_item(OP_DATA, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 6) == 0) queue_item(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
    queue_item(last_doc ? OP_DOC_LAST : OP_DOC_SEP, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_ALIGN_EOL:       cfg_align = value[0];
      REG_LINE_PADDING:    cfg_pad = value;
      REG_BLACK_SEPARATOR: cfg_sep = value[0];
      default:             cfg_top = value[1:0];
    endcase
  endtask

  task automatic set_config(int align, int pad, int sep, int top);
    write_reg(REG_ALIGN_EOL, 4'(align));
    write_reg(REG_LINE_PADDING, 4'(pad));
    write_reg(REG_BLACK_SEPARATOR, 4'(sep));
    write_reg(REG_TOP_BLANK_LINES, 4'(top));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold new stimulus until every predicted byte has arrived, then give the
  // decoder time to finish work that produces no output.
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    fax_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.op = s_tuser;
        it.data = s_tdata;
        predict_transfer(it);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= it.op;
          s_tdata <= it.data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: its own stall pattern, changed as its phase counter wraps, plus
  // one long hold-off early in the run that backs the block up into its input.
  // ---------------------------------------------------------------------
  int ready_mode = 0;
  int ready_phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      ready_phase <= (ready_phase + 1) % 64;
      if (ready_phase == 63) ready_mode <= $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (!hold_done && bytes_seen >= 30) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        m_tready <= 1'b0;
      end else if (ready_mode == 0) begin
        m_tready <= 1'b1;
      end else if (ready_mode == 1) begin
        m_tready <= $urandom_range(0, 1);
      end else begin
        m_tready <= (ready_phase % 5) < 2;
      end
    end
  end

  // Monitor: every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    fax_byte_t e;
    if (!rst && m_tvalid && m_tready) begin
      bytes_seen <= bytes_seen + 1;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte %02h last %0b", $time, m_tdata, m_tlast);
      end else begin
        e = expected_bytes.pop_front();
        if (m_tdata !== e.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, e.out_byte, m_tdata);
        end
        if (m_tlast !== e.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, e.last, m_tlast);
        end
      end
    end
  end

  // Watchdog: too long without any transfer while work is outstanding.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (pending_items.size() == 0 && !s_tvalid && expected_bytes.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("fax_mh_line_normalizer_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: an RTC with no document, data before
    // any document start, extreme bytes, every op code including unused ones.
    queue_item(OP_FINISH, 8'h00);
    queue_item(OP_DATA, 8'hff);
    queue_item(OP_DATA, 8'h00);
    queue_item(OP_DATA, 8'hff);
    queue_item(OP_DOC_START, 8'hff);
    add_code(wterm[0]);
    add_code(bterm[63]);
    add_code(wmake[26]);
    add_code(wterm[63]);
    add_code(bmake[26]);
    add_code(bterm[0]);
    add_code(xmake[12]);
    add_code(wterm[5]);
    add_eol();
    add_code("0000001");       // reads as white run code 29 with the EOL's first zero
    add_eol();
    add_eol();
    add_zeros(24);
    pack_bits(1'b1);
    queue_item(OP_DOC_SEP, 8'h00);
    queue_item(3'd5, 8'h00);
    queue_item(3'd6, 8'hff);
    queue_item(3'd7, 8'h00);
    queue_item(OP_DOC_LAST, 8'h00);
    queue_item(OP_FINISH, 8'hff);
    drain();

    // Random documents under several settings, the extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(1, 8, 1, 3);
        1: set_config(0, 15, 0, 2);
        2: set_config(1, 0, 1, 1);
        3: set_config(0, 3, 0, 0);
        default: set_config(0, 0, 1, 3);
      endcase
      for (int d = 0; d < 2; d++) add_document($urandom_range(2, 4), d == 1);
      if ($urandom_range(0, 1) == 0) queue_item(OP_DATA, 8'($urandom_range(0, 255)));
      queue_item(OP_FINISH, 8'($urandom_range(0, 255)));
      drain();
    end

    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("fax_mh_line_normalizer_tb OK");
    end else begin
      $display("fax_mh_line_normalizer_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
